/* sv/cbb_pkg.sv */
`default_nettype none
package cbb_pkg;

  // Coordinate and result widths
  localparam int CoordW = 24;
  localparam int ValW   = 48;
  localparam int OutW   = 16;

  // Stage layout of one axis pipeline
  localparam int SqFirst  = 3;
  localparam int SqSteps  = 26;
  localparam int NumStage = SqFirst + SqSteps;   // root numerators
  localparam int AbsStage = NumStage + 1;        // magnitudes
  localparam int DivInit  = NumStage + 2;        // dividend, range check
  localparam int DivFirst = NumStage + 3;
  localparam int DivSteps = 16;
  localparam int TStage   = DivFirst + DivSteps; // root done, seed Horner
  localparam int HorFirst = TStage + 1;
  localparam int MinMax0  = HorFirst + 6;
  localparam int MinMax1  = MinMax0 + 1;
  localparam int AxisDepth = MinMax1 + 1;

  // Payload carried along one axis pipeline
  typedef struct packed {
    logic signed [23:0] p0;
    logic signed [26:0] a;
    logic signed [25:0] b;
    logic signed [24:0] c;
    logic signed [47:0] lo;
    logic signed [47:0] hi;
    logic signed [52:0] bb;
    logic signed [52:0] ac;
    logic               ok;
    logic [51:0]        rad;
    logic [29:0]        srem;
    logic [25:0]        root;
    logic               use0;
    logic               use1;
    logic signed [27:0] n0;
    logic signed [27:0] n1;
    logic [27:0]        mn0;
    logic [27:0]        mn1;
    logic [26:0]        ma;
    logic [29:0]        drem0;
    logic [29:0]        drem1;
    logic [15:0]        dlow0;
    logic [15:0]        dlow1;
    logic [15:0]        q0;
    logic [15:0]        q1;
    logic signed [47:0] v0;
    logic signed [47:0] v1;
    logic signed [64:0] pr0;
    logic signed [64:0] pr1;
  } axis_t;

  // Product scaled down by 2^16, rounded half away from zero
  function automatic logic signed [47:0] round16(input logic signed [64:0] pr);
    logic [64:0] mag;
    logic [48:0] m;
    begin
      mag = pr[64] ? 65'(-pr) : 65'(pr);
      m = 49'((mag + 65'd32768) >> 16);
      round16 = pr[64] ? 48'(-$signed({1'b0, m})) : 48'(m);
    end
  endfunction

  // Lowest value to whole pixels, rounded and saturated
  function automatic logic [15:0] origin_px(input logic signed [47:0] v);
    logic [47:0]        mag;
    logic [24:0]        m;
    logic signed [25:0] r;
    begin
      mag = v[47] ? 48'(-v) : 48'(v);
      m = 25'((mag + 48'd8388608) >> 24);
      r = v[47] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (r < -26'sd32768) begin
        origin_px = 16'h8000;
      end else if (r > 26'sd32767) begin
        origin_px = 16'h7fff;
      end else begin
        origin_px = r[15:0];
      end
    end
  endfunction

  // Extent to whole pixels, rounded and saturated
  function automatic logic [15:0] size_px(input logic signed [47:0] lo,
                                          input logic signed [47:0] hi);
    logic signed [48:0] d;
    logic [25:0]        m;
    begin
      d = 49'(hi) - 49'(lo);
      m = 26'((d[47:0] + 48'd8388608) >> 24);
      if (d[48]) begin
        size_px = 16'd0;
      end else if (m > 26'd65535) begin
        size_px = 16'hffff;
      end else begin
        size_px = m[15:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

/* sv/cbb_axis.sv */
`default_nettype none
module cbb_axis (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [23:0] p0,
  input  wire logic signed [23:0] p1,
  input  wire logic signed [23:0] p2,
  input  wire logic signed [23:0] p3,
  output logic signed [47:0]      lo,
  output logic signed [47:0]      hi
);

  cbb_pkg::axis_t st [cbb_pkg::AxisDepth];
  cbb_pkg::axis_t nx [cbb_pkg::AxisDepth];

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < cbb_pkg::AxisDepth; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  // Coefficients and end point bounds
  logic signed [26:0] e0, e1, e2, e3;
  logic signed [47:0] x0, x3;
  assign e0 = 27'(p0);
  assign e1 = 27'(p1);
  assign e2 = 27'(p2);
  assign e3 = 27'(p3);
  assign x0 = {{8{p0[23]}}, p0, 16'b0};
  assign x3 = {{8{p3[23]}}, p3, 16'b0};

  always_comb begin
    nx[0] = '0;
    nx[0].p0 = p0;
    nx[0].a = e3 - 27'sd3 * e2 + 27'sd3 * e1 - e0;
    nx[0].b = 26'(e0 - (e1 <<< 1) + e2);
    nx[0].c = 25'(e1 - e0);
    nx[0].lo = (x3 < x0) ? x3 : x0;
    nx[0].hi = (x3 > x0) ? x3 : x0;
  end

  // Discriminant products
  always_comb begin
    nx[1] = st[0];
    nx[1].bb = 53'(st[0].b) * 53'(st[0].b);
    nx[1].ac = 53'(st[0].a) * 53'(st[0].c);
  end

  // Discriminant, gate on nonzero leading term and nonnegative value
  logic signed [52:0] disc;
  assign disc = st[1].bb - st[1].ac;
  always_comb begin
    nx[2] = st[1];
    nx[2].ok = (st[1].a != '0) && !disc[52];
    nx[2].rad = nx[2].ok ? disc[51:0] : '0;
    nx[2].srem = '0;
    nx[2].root = '0;
  end

  // Integer square root, two radicand bits per stage
  for (genvar k = 0; k < cbb_pkg::SqSteps; k++) begin : g_sqrt
    logic [29:0] tr, trial;
    assign tr = {st[cbb_pkg::SqFirst + k - 1].srem[27:0],
                 st[cbb_pkg::SqFirst + k - 1].rad[51 - 2 * k -: 2]};
    assign trial = {2'b0, st[cbb_pkg::SqFirst + k - 1].root, 2'b01};
    always_comb begin
      nx[cbb_pkg::SqFirst + k] = st[cbb_pkg::SqFirst + k - 1];
      if (tr >= trial) begin
        nx[cbb_pkg::SqFirst + k].srem = tr - trial;
        nx[cbb_pkg::SqFirst + k].root =
          {st[cbb_pkg::SqFirst + k - 1].root[24:0], 1'b1};
      end else begin
        nx[cbb_pkg::SqFirst + k].srem = tr;
        nx[cbb_pkg::SqFirst + k].root =
          {st[cbb_pkg::SqFirst + k - 1].root[24:0], 1'b0};
      end
    end
  end

  // Root numerators and sign match against the leading term
  logic signed [27:0] nb, sx;
  assign nb = -28'(st[cbb_pkg::NumStage - 1].b);
  assign sx = {2'b0, st[cbb_pkg::NumStage - 1].root};
  always_comb begin
    nx[cbb_pkg::NumStage] = st[cbb_pkg::NumStage - 1];
    nx[cbb_pkg::NumStage].n0 = nb + sx;
    nx[cbb_pkg::NumStage].n1 = nb - sx;
    nx[cbb_pkg::NumStage].use0 = st[cbb_pkg::NumStage - 1].ok && (nb + sx != '0) &&
      ((nb + sx) < 0) == st[cbb_pkg::NumStage - 1].a[26];
    nx[cbb_pkg::NumStage].use1 = st[cbb_pkg::NumStage - 1].ok && (nb - sx != '0) &&
      ((nb - sx) < 0) == st[cbb_pkg::NumStage - 1].a[26];
  end

  // Magnitudes of numerators and leading term
  always_comb begin
    nx[cbb_pkg::AbsStage] = st[cbb_pkg::NumStage];
    nx[cbb_pkg::AbsStage].mn0 = st[cbb_pkg::NumStage].n0[27] ?
      28'(-st[cbb_pkg::NumStage].n0) : 28'(st[cbb_pkg::NumStage].n0);
    nx[cbb_pkg::AbsStage].mn1 = st[cbb_pkg::NumStage].n1[27] ?
      28'(-st[cbb_pkg::NumStage].n1) : 28'(st[cbb_pkg::NumStage].n1);
    nx[cbb_pkg::AbsStage].ma = st[cbb_pkg::NumStage].a[26] ?
      27'(-st[cbb_pkg::NumStage].a) : 27'(st[cbb_pkg::NumStage].a);
  end

  // Dividend with half-divisor bias, drop roots at or past the far end
  logic [45:0] nd0, nd1, lim;
  assign nd0 = {1'b0, st[cbb_pkg::AbsStage].mn0, 17'b0} + 46'(st[cbb_pkg::AbsStage].ma);
  assign nd1 = {1'b0, st[cbb_pkg::AbsStage].mn1, 17'b0} + 46'(st[cbb_pkg::AbsStage].ma);
  assign lim = {2'b0, st[cbb_pkg::AbsStage].ma, 17'b0};
  always_comb begin
    nx[cbb_pkg::DivInit] = st[cbb_pkg::AbsStage];
    nx[cbb_pkg::DivInit].use0 = st[cbb_pkg::AbsStage].use0 && (nd0 < lim);
    nx[cbb_pkg::DivInit].use1 = st[cbb_pkg::AbsStage].use1 && (nd1 < lim);
    nx[cbb_pkg::DivInit].drem0 = nd0[45:16];
    nx[cbb_pkg::DivInit].drem1 = nd1[45:16];
    nx[cbb_pkg::DivInit].dlow0 = nd0[15:0];
    nx[cbb_pkg::DivInit].dlow1 = nd1[15:0];
    nx[cbb_pkg::DivInit].q0 = '0;
    nx[cbb_pkg::DivInit].q1 = '0;
  end

  // Restoring division, one quotient bit per stage for both roots
  for (genvar k = 0; k < cbb_pkg::DivSteps; k++) begin : g_div
    logic [30:0] tr0, tr1, dv;
    assign tr0 = {st[cbb_pkg::DivFirst + k - 1].drem0,
                  st[cbb_pkg::DivFirst + k - 1].dlow0[15 - k]};
    assign tr1 = {st[cbb_pkg::DivFirst + k - 1].drem1,
                  st[cbb_pkg::DivFirst + k - 1].dlow1[15 - k]};
    assign dv = {3'b0, st[cbb_pkg::DivFirst + k - 1].ma, 1'b0};
    always_comb begin
      nx[cbb_pkg::DivFirst + k] = st[cbb_pkg::DivFirst + k - 1];
      nx[cbb_pkg::DivFirst + k].drem0 = (tr0 >= dv) ? 30'(tr0 - dv) : tr0[29:0];
      nx[cbb_pkg::DivFirst + k].drem1 = (tr1 >= dv) ? 30'(tr1 - dv) : tr1[29:0];
      nx[cbb_pkg::DivFirst + k].q0 =
        {st[cbb_pkg::DivFirst + k - 1].q0[14:0], tr0 >= dv};
      nx[cbb_pkg::DivFirst + k].q1 =
        {st[cbb_pkg::DivFirst + k - 1].q1[14:0], tr1 >= dv};
    end
  end

  // Drop roots that quantize to zero, seed Horner with the leading term
  always_comb begin
    nx[cbb_pkg::TStage] = st[cbb_pkg::TStage - 1];
    nx[cbb_pkg::TStage].use0 = st[cbb_pkg::TStage - 1].use0 &&
                               (st[cbb_pkg::TStage - 1].q0 != '0);
    nx[cbb_pkg::TStage].use1 = st[cbb_pkg::TStage - 1].use1 &&
                               (st[cbb_pkg::TStage - 1].q1 != '0);
    nx[cbb_pkg::TStage].v0 = {{5{st[cbb_pkg::TStage - 1].a[26]}},
                              st[cbb_pkg::TStage - 1].a, 16'b0};
    nx[cbb_pkg::TStage].v1 = nx[cbb_pkg::TStage].v0;
  end

  // Horner steps: multiply by t, then round and add the next term
  for (genvar r = 0; r < 3; r++) begin : g_hor
    localparam int M = cbb_pkg::HorFirst + 2 * r;
    logic signed [47:0] addend;
    if (r == 0) begin : g_b
      assign addend = (48'(st[M].b) * 48'sd3) <<< 16;
    end else if (r == 1) begin : g_c
      assign addend = (48'(st[M].c) * 48'sd3) <<< 16;
    end else begin : g_p
      assign addend = 48'(st[M].p0) <<< 16;
    end
    always_comb begin
      nx[M] = st[M - 1];
      nx[M].pr0 = 65'(st[M - 1].v0) * 65'($signed({1'b0, st[M - 1].q0}));
      nx[M].pr1 = 65'(st[M - 1].v1) * 65'($signed({1'b0, st[M - 1].q1}));
    end
    always_comb begin
      nx[M + 1] = st[M];
      nx[M + 1].v0 = cbb_pkg::round16(st[M].pr0) + addend;
      nx[M + 1].v1 = cbb_pkg::round16(st[M].pr1) + addend;
    end
  end

  // Widen bounds by the first root, then by the second
  always_comb begin
    nx[cbb_pkg::MinMax0] = st[cbb_pkg::MinMax0 - 1];
    if (st[cbb_pkg::MinMax0 - 1].use0) begin
      if (st[cbb_pkg::MinMax0 - 1].v0 < st[cbb_pkg::MinMax0 - 1].lo) begin
        nx[cbb_pkg::MinMax0].lo = st[cbb_pkg::MinMax0 - 1].v0;
      end
      if (st[cbb_pkg::MinMax0 - 1].v0 > st[cbb_pkg::MinMax0 - 1].hi) begin
        nx[cbb_pkg::MinMax0].hi = st[cbb_pkg::MinMax0 - 1].v0;
      end
    end
  end

  always_comb begin
    nx[cbb_pkg::MinMax1] = st[cbb_pkg::MinMax0];
    if (st[cbb_pkg::MinMax0].use1) begin
      if (st[cbb_pkg::MinMax0].v1 < st[cbb_pkg::MinMax0].lo) begin
        nx[cbb_pkg::MinMax1].lo = st[cbb_pkg::MinMax0].v1;
      end
      if (st[cbb_pkg::MinMax0].v1 > st[cbb_pkg::MinMax0].hi) begin
        nx[cbb_pkg::MinMax1].hi = st[cbb_pkg::MinMax0].v1;
      end
    end
  end

  assign lo = st[cbb_pkg::MinMax1].lo;
  assign hi = st[cbb_pkg::MinMax1].hi;

endmodule
`default_nettype wire

/* sv/cubic_bezier_bounding_box_top.sv */
// Accepts one curve per cycle unless the output stalls; 57 stages per axis
// (26 square root and 16 divide steps among them) plus one output register.
// A stall at the output holds the whole pipeline; no word is lost or repeated.
// Reset clears the stage valid bits and the output valid; data is not reset.
`default_nettype none
module cubic_bezier_bounding_box_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
  input  wire logic [191:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // box_left, box_top, box_width, box_height
  output logic [63:0]       m_axis_tdata
);

  logic                            ce;
  logic [cbb_pkg::AxisDepth - 1:0] vld;
  logic signed [47:0]              xlo, xhi, ylo, yhi;

  // Advance when the output register is free or being taken
  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce && !rst;

  cbb_axis u_x (
    .clk (clk),
    .ce  (ce),
    .p0  (s_axis_tdata[23:0]),
    .p1  (s_axis_tdata[71:48]),
    .p2  (s_axis_tdata[119:96]),
    .p3  (s_axis_tdata[167:144]),
    .lo  (xlo),
    .hi  (xhi)
  );

  cbb_axis u_y (
    .clk (clk),
    .ce  (ce),
    .p0  (s_axis_tdata[47:24]),
    .p1  (s_axis_tdata[95:72]),
    .p2  (s_axis_tdata[143:120]),
    .p3  (s_axis_tdata[191:168]),
    .lo  (ylo),
    .hi  (yhi)
  );

  // Shift valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      vld <= {vld[cbb_pkg::AxisDepth - 2:0], s_axis_tvalid};
      m_axis_tvalid <= vld[cbb_pkg::AxisDepth - 1];
    end
  end

  // Round and saturate into the output word
  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= {cbb_pkg::size_px(ylo, yhi), cbb_pkg::size_px(xlo, xhi),
                       cbb_pkg::origin_px(ylo), cbb_pkg::origin_px(xlo)};
    end
  end

endmodule
`default_nettype wire
